// ===== hdl/uart_rx_ring_line_buffer_top_assert.svh =====
// Assertion macros shared by the serial receive ring buffer RTL.
`ifndef UART_RX_RING_LINE_BUFFER_TOP_ASSERT_SVH
`define UART_RX_RING_LINE_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define URLB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define URLB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define URLB_ASSERT_IMPLY(label, ante, cons, msg)
`define URLB_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/urlb_pkg.sv =====
// Package: types, constants and index helpers for the receive ring buffer.
package urlb_pkg;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int LEN_W      = 6;
    localparam int LIMIT_W    = 12;

    localparam logic [1:0] OP_RECEIVE = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_LINE    = 2'd2;
    localparam logic [1:0] OP_COUNT   = 2'd3;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         rx_byte;
        logic [LIMIT_W-1:0] line_limit;
    } urlb_in_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             present;
        logic [LEN_W-1:0] length;
        logic             is_status;
        logic             last;
    } urlb_out_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
        logic [IDX_W:0] s;
        s = {1'b0, i} + 1'b1;
        return (s >= (IDX_W+1)'(RING_DEPTH)) ? '0 : s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] ring_dist(input logic [IDX_W-1:0] from,
                                                   input logic [IDX_W-1:0] to);
        logic [IDX_W:0] t;
        if (to >= from)
        begin
            t = {1'b0, to} - {1'b0, from};
        end
        else
        begin
            t = (IDX_W+1)'(RING_DEPTH) - {1'b0, from} + {1'b0, to};
        end
        return t[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/urlb_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
module urlb_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/uart_rx_ring_line_buffer_top.sv =====
// Top level: serial receive ring buffer with CR LF line extraction.
// Results: count, empty pop, zero-limit line: registered in the cycle after the transfer; pop: read in
//   S_POP, then registered; receive gives none. Read line: scan of the stored bytes from the read
//   index up to the write index; a found line then streams its bytes (S_COPY) and a status (S_DONE).
// One item at a time: next transfer from the cycle the last result shows; receiver cannot stall.
// Reset (rst_n, async): indices cleared, ring empty; RAM contents not cleared.
`include "uart_rx_ring_line_buffer_top_assert.svh"
module uart_rx_ring_line_buffer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  urlb_pkg::urlb_in_t  cmd,
    output logic                result_valid,
    output urlb_pkg::urlb_out_t result
);
    import urlb_pkg::*;

    // One-hot sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_POP  = 5'b00010,
        S_SCAN = 5'b00100,
        S_COPY = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t             state_reg,    state_next;
    logic [IDX_W-1:0]   wr_reg,       wr_next;
    logic [IDX_W-1:0]   rd_reg,       rd_next;
    // ptr: next RAM address to fetch during scan or copy
    logic [IDX_W-1:0]   ptr_reg,      ptr_next;
    // cnt: index of the byte under check (scan) or fetches left (copy)
    logic [IDX_W-1:0]   cnt_reg,      cnt_next;
    // vld: RAM read data belongs to a fetch issued last cycle
    logic               vld_reg,      vld_next;
    logic               prev_cr_reg,  prev_cr_next;
    logic [LIMIT_W-1:0] limit_reg,    limit_next;
    logic [IDX_W-1:0]   copy_len_reg, copy_len_next;
    logic               res_valid_reg, res_valid_next;
    urlb_out_t          res_reg,      res_next;

    logic               accept;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [IDX_W-1:0]   ram_raddr;
    logic [7:0]         ram_rdata;

    logic [IDX_W-1:0]   wr_inc;
    logic [IDX_W-1:0]   line_len;
    logic [LIMIT_W-1:0] lim_m1;
    logic [IDX_W-1:0]   cut_len;

    urlb_ram #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (IDX_W),
        .DATA_W (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign wr_inc    = ring_next(wr_reg);
    assign ram_waddr = wr_reg;

    // Line length is the index of the CR, one before the LF under check.
    // Cut to limit-1 when the host buffer is too small; that case implies
    // limit-1 < line length, so it fits the index width.
    assign line_len = cnt_reg - 1'b1;
    assign lim_m1   = limit_reg - 1'b1;
    assign cut_len  = (LIMIT_W'(line_len) >= limit_reg) ? lim_m1[IDX_W-1:0] : line_len;

    always_comb
    begin
        state_next     = state_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        vld_next       = 1'b0;
        prev_cr_next   = prev_cr_reg;
        limit_next     = limit_reg;
        copy_len_next  = copy_len_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        ram_we         = 1'b0;
        ram_raddr      = rd_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_RECEIVE:
                        begin
                            // Push; on a full ring the oldest byte goes
                            ram_we  = 1'b1;
                            wr_next = wr_inc;
                            if (wr_inc == rd_reg)
                            begin
                                rd_next = ring_next(rd_reg);
                            end
                        end
                        OP_POP:
                        begin
                            if (wr_reg == rd_reg)
                            begin
                                res_valid_next = 1'b1;
                                res_next.last  = 1'b1;
                            end
                            else
                            begin
                                // RAM fetch of rd already under way this cycle
                                state_next = S_POP;
                            end
                        end
                        OP_COUNT:
                        begin
                            res_valid_next     = 1'b1;
                            res_next.length    = LEN_W'(ring_dist(rd_reg, wr_reg));
                            res_next.is_status = 1'b1;
                            res_next.last      = 1'b1;
                        end
                        OP_LINE:
                        begin
                            if (cmd.line_limit == '0)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.is_status = 1'b1;
                                res_next.last      = 1'b1;
                            end
                            else
                            begin
                                limit_next   = cmd.line_limit;
                                ptr_next     = rd_reg;
                                cnt_next     = '0;
                                prev_cr_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                res_valid_next     = 1'b1;
                res_next.data_byte = ram_rdata;
                res_next.present   = 1'b1;
                res_next.last      = 1'b1;
                rd_next            = ring_next(rd_reg);
                state_next         = S_IDLE;
            end

            S_SCAN:
            begin
                // Fetch one byte a cycle up to the write index
                ram_raddr = ptr_reg;
                if (ptr_reg != wr_reg)
                begin
                    ptr_next = ring_next(ptr_reg);
                    vld_next = 1'b1;
                end
                if (vld_reg)
                begin
                    if (prev_cr_reg && (ram_rdata == CHAR_LF))
                    begin
                        // CR LF found: rewind to rd and copy the line out
                        copy_len_next = cut_len;
                        cnt_next      = cut_len;
                        ptr_next      = rd_reg;
                        vld_next      = 1'b0;
                        state_next    = S_COPY;
                    end
                    else
                    begin
                        prev_cr_next = (ram_rdata == CHAR_CR);
                        cnt_next     = cnt_reg + 1'b1;
                    end
                end
                else if (ptr_reg == wr_reg)
                begin
                    // Ring exhausted without a complete line
                    res_valid_next     = 1'b1;
                    res_next.is_status = 1'b1;
                    res_next.last      = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_COPY:
            begin
                ram_raddr = ptr_reg;
                if (cnt_reg != '0)
                begin
                    ptr_next = ring_next(ptr_reg);
                    cnt_next = cnt_reg - 1'b1;
                    vld_next = 1'b1;
                end
                if (vld_reg)
                begin
                    res_valid_next     = 1'b1;
                    res_next.data_byte = ram_rdata;
                    res_next.present   = 1'b1;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Status, then skip the two bytes after the copied bytes (the CR LF pair unless the line was cut)
                res_valid_next     = 1'b1;
                res_next.present   = 1'b1;
                res_next.length    = LEN_W'(copy_len_reg);
                res_next.is_status = 1'b1;
                res_next.last      = 1'b1;
                rd_next            = ring_next(ring_next(ptr_reg));
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wr_reg        <= '0;
            rd_reg        <= '0;
            vld_reg       <= 1'b0;
            prev_cr_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_reg        <= wr_next;
            rd_reg        <= rd_next;
            vld_reg       <= vld_next;
            prev_cr_reg   <= prev_cr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg      <= ptr_next;
        cnt_reg      <= cnt_next;
        limit_reg    <= limit_next;
        copy_len_reg <= copy_len_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `URLB_ASSERT_NEXT(a_push_not_empty, accept && (cmd.operation == OP_RECEIVE), wr_reg != rd_reg, "ring empty after a push")
    `URLB_ASSERT_NEXT(a_pop_fetch, accept && (cmd.operation == OP_POP) && (wr_reg != rd_reg), state_reg == S_POP, "pop of a non-empty ring did not fetch")
    `URLB_ASSERT_IMPLY(a_data_in_copy, result_valid && !result.is_status && !result.last, state_reg == S_COPY || state_reg == S_DONE, "line byte outside copy")
    `URLB_ASSERT_IMPLY(a_idle_no_fetch, !busy, !vld_reg, "fetch pending while idle")
    `URLB_ASSERT_IMPLY(a_status_last, result_valid && result.is_status, result.last, "status result not final")

endmodule
